/* sv/pdtp_pkg.sv */
package pdtp_pkg;

   localparam int unsigned FIELD_W = 12;

   localparam logic [FIELD_W-1:0] MAX_TAG_BYTES_RESET = 12'd1494;

   localparam logic [15:0] TAG_EOL     = 16'h0000;
   localparam logic [15:0] TAG_SERVICE = 16'h0101;
   localparam logic [15:0] TAG_HOST    = 16'h0103;
   localparam logic [15:0] TAG_COOKIE  = 16'h0104;
   localparam logic [15:0] TAG_RELAY   = 16'h0110;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVER_LEN  = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       empty_req;
   } item_type;

   typedef struct packed {
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] len;
   } rec_type;

   typedef struct packed {
      logic               found;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] len;
   } tag_info_type;

   typedef struct packed {
      status_type   status;
      tag_info_type service;
      logic         relay_found;
      tag_info_type host;
      tag_info_type cookie;
   } result_type;

   typedef struct packed {
      logic     valid;
      logic     advance;
      item_type item;
   } stage_ctl_type;

endpackage

/* sv/pdtp_req_if.sv */
interface pdtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   logic       empty_req;

   modport source (output valid, data_byte, last, empty_req, input ready);
   modport sink (input valid, data_byte, last, empty_req, output ready);
endinterface

/* sv/pdtp_rsp_if.sv */
interface pdtp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        service_found;
   logic [11:0] service_offset;
   logic [11:0] service_len;
   logic        relay_found;
   logic        host_found;
   logic [11:0] host_offset;
   logic [11:0] host_len;
   logic        cookie_found;
   logic [11:0] cookie_offset;
   logic [11:0] cookie_length;

   modport source (
      output valid, status, service_found, service_offset, service_len, relay_found,
             host_found, host_offset, host_len, cookie_found, cookie_offset, cookie_length,
      input ready
   );
   modport sink (
      input valid, status, service_found, service_offset, service_len, relay_found,
            host_found, host_offset, host_len, cookie_found, cookie_offset, cookie_length,
      output ready
   );
endinterface

/* sv/pdtp_in_reg.sv */
module pdtp_in_reg
   import pdtp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   pdtp_req_if.sink      req,
   input  logic          advance,
   output stage_ctl_type stage
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;
   assign valid_in  = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{data_byte: req.data_byte, last: req.last, empty_req: req.empty_req};
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.advance = advance;
   assign stage.item    = item_ff;

endmodule

/* sv/pdtp_tag_walker.sv */
module pdtp_tag_walker
   import pdtp_pkg::*;
#(
   parameter int unsigned MAX_AREA_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  stage_ctl_type      stage,
   input  logic [FIELD_W-1:0] max_tag_bytes,
   output result_type         result
);

   localparam int unsigned CW   = $clog2(MAX_AREA_BYTES);
   localparam int unsigned CMPW = (CW > FIELD_W) ? CW : FIELD_W;
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_AREA_BYTES - 1);

   localparam int unsigned FL_SERVICE = 0;
   localparam int unsigned FL_RELAY   = 1;
   localparam int unsigned FL_HOST    = 2;
   localparam int unsigned FL_COOKIE  = 3;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_VALUE  = 2'd1,
      PH_DONE   = 2'd2
   } phase_type;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          over_ff, over_in;
   phase_type     phase_ff, phase_in;
   logic [1:0]    hpos_ff, hpos_in;
   logic [23:0]   hshift_ff, hshift_in;
   logic [15:0]   vleft_ff, vleft_in;
   logic [3:0]    flags_ff, flags_in;
   rec_type       service_ff, service_in;
   rec_type       host_ff, host_in;
   rec_type       cookie_ff, cookie_in;

   logic [15:0]   tag_kind;
   logic [15:0]   tag_len;
   logic [CMPW-1:0] cnt_ext;
   rec_type       new_rec;
   status_type    status;
   logic          fire;

   assign fire     = stage.valid && stage.advance;
   assign tag_kind = hshift_ff[23:8];
   assign tag_len  = {hshift_ff[7:0], stage.item.data_byte};

   always_comb begin
      cnt_in     = cnt_ff;
      over_in    = over_ff;
      phase_in   = phase_ff;
      hpos_in    = hpos_ff;
      hshift_in  = hshift_ff;
      vleft_in   = vleft_ff;
      flags_in   = flags_ff;
      service_in = service_ff;
      host_in    = host_ff;
      cookie_in  = cookie_ff;
      cnt_ext    = '0;
      new_rec    = '0;
      if (!stage.item.empty_req) begin
         if (cnt_ff >= COUNT_MAX) begin
            over_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CW'(1);
         end
         cnt_ext = CMPW'(cnt_in);
         new_rec = '{offset: cnt_ext[FIELD_W-1:0], len: tag_len[FIELD_W-1:0]};
         case (phase_ff)
            PH_HEADER: begin
               if (hpos_ff != 2'd3) begin
                  hshift_in = {hshift_ff[15:0], stage.item.data_byte};
                  hpos_in   = hpos_ff + 2'd1;
               end else begin
                  hpos_in   = 2'd0;
                  hshift_in = '0;
                  if (tag_kind == TAG_EOL) begin
                     phase_in = PH_DONE;
                  end else begin
                     case (tag_kind)
                        TAG_SERVICE: begin
                           flags_in[FL_SERVICE] = 1'b1;
                           service_in = new_rec;
                        end
                        TAG_HOST: begin
                           flags_in[FL_HOST] = 1'b1;
                           host_in = new_rec;
                        end
                        TAG_COOKIE: begin
                           flags_in[FL_COOKIE] = 1'b1;
                           cookie_in = new_rec;
                        end
                        TAG_RELAY: begin
                           flags_in[FL_RELAY] = 1'b1;
                        end
                        default: begin
                        end
                     endcase
                     vleft_in = tag_len;
                     if (tag_len != 16'd0) begin
                        phase_in = PH_VALUE;
                     end
                  end
               end
            end
            PH_VALUE: begin
               vleft_in = vleft_ff - 16'd1;
               if (vleft_in == 16'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (over_in || (CMPW'(cnt_in) > CMPW'(max_tag_bytes))) begin
         status = STATUS_OVER_LEN;
      end else if (phase_in == PH_DONE) begin
         status = STATUS_OK;
      end else if (phase_in == PH_VALUE || hpos_in != 2'd0) begin
         status = STATUS_TRUNCATED;
      end else begin
         status = STATUS_OK;
      end
      result = '0;
      result.status = status;
      if (status == STATUS_OK) begin
         result.relay_found = flags_in[FL_RELAY];
         if (flags_in[FL_SERVICE]) begin
            result.service = '{found: 1'b1, offset: service_in.offset, len: service_in.len};
         end
         if (flags_in[FL_HOST]) begin
            result.host = '{found: 1'b1, offset: host_in.offset, len: host_in.len};
         end
         if (flags_in[FL_COOKIE]) begin
            result.cookie = '{found: 1'b1, offset: cookie_in.offset, len: cookie_in.len};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && stage.item.last)) begin
         cnt_ff     <= '0;
         over_ff    <= 1'b0;
         phase_ff   <= PH_HEADER;
         hpos_ff    <= '0;
         hshift_ff  <= '0;
         vleft_ff   <= '0;
         flags_ff   <= '0;
         service_ff <= '0;
         host_ff    <= '0;
         cookie_ff  <= '0;
      end else if (fire) begin
         cnt_ff     <= cnt_in;
         over_ff    <= over_in;
         phase_ff   <= phase_in;
         hpos_ff    <= hpos_in;
         hshift_ff  <= hshift_in;
         vleft_ff   <= vleft_in;
         flags_ff   <= flags_in;
         service_ff <= service_in;
         host_ff    <= host_in;
         cookie_ff  <= cookie_in;
      end
   end

endmodule

/* sv/pdtp_out_reg.sv */
module pdtp_out_reg
   import pdtp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       free,
   pdtp_rsp_if.source rsp
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign free     = !valid_ff || rsp.ready;
   assign valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.status         = res_ff.status;
   assign rsp.service_found  = res_ff.service.found;
   assign rsp.service_offset = res_ff.service.offset;
   assign rsp.service_len    = res_ff.service.len;
   assign rsp.relay_found    = res_ff.relay_found;
   assign rsp.host_found     = res_ff.host.found;
   assign rsp.host_offset    = res_ff.host.offset;
   assign rsp.host_len       = res_ff.host.len;
   assign rsp.cookie_found   = res_ff.cookie.found;
   assign rsp.cookie_offset  = res_ff.cookie.offset;
   assign rsp.cookie_length  = res_ff.cookie.len;

endmodule

/* sv/pppoe_discovery_tag_parser_core.sv */
// channel | direction | transfer                  | payload
// req     | in        | valid && ready at clock   | data_byte, last, empty_req
// rsp     | out       | valid && ready at clock   | status and tag summary
// csr     | in        | csr_we at clock           | csr_wdata = max_tag_bytes
//
// One item per cycle unless a held summary stalls a last item: input register, one pass of tag logic, result register.
// A summary is loaded into the result register when its last item, held in the input register, advances.
// Reset clears packet state and loads max_tag_bytes with 1494.
// A held summary stalls only items marked last; other bytes keep flowing.
module pppoe_discovery_tag_parser_core
   import pdtp_pkg::*;
#(
   parameter int unsigned MAX_AREA_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   pdtp_req_if.sink           req,
   pdtp_rsp_if.source         rsp,
   input  logic               csr_we,
   input  logic [FIELD_W-1:0] csr_wdata
);

   logic [FIELD_W-1:0] max_ff;
   stage_ctl_type      stage;
   result_type         result;
   logic               out_free;
   logic               advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_TAG_BYTES_RESET;
      end else if (csr_we) begin
         max_ff <= csr_wdata;
      end
   end

   assign advance = stage.valid && (!stage.item.last || out_free);

   pdtp_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .advance (advance),
      .stage   (stage)
   );

   pdtp_tag_walker #(
      .MAX_AREA_BYTES (MAX_AREA_BYTES)
   ) u_walker (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .max_tag_bytes (max_ff),
      .result        (result)
   );

   pdtp_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && stage.item.last),
      .result (result),
      .free   (out_free),
      .rsp    (rsp)
   );

endmodule
